// ===== design/app_pc_pkg.sv =====
`default_nettype none
package app_pc_pkg;

    localparam int HIST_DEPTH = 9;
    localparam int KW_MAX_LEN = 10;
    localparam int NUM_KW = 18;
    localparam int NUM_PORT_ENTRIES = 13;
    localparam int COUNT_W = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DPI_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_ENABLE = 1'd1;

    localparam logic [1:0] TR_OTHER = 2'd0;
    localparam logic [1:0] TR_TCP = 2'd1;
    localparam logic [1:0] TR_UDP = 2'd2;

    localparam logic [3:0] PROTO_UNKNOWN = 4'd0;
    localparam logic [3:0] PROTO_HTTP = 4'd1;
    localparam logic [3:0] PROTO_HTTPS = 4'd2;
    localparam logic [3:0] PROTO_DNS = 4'd3;
    localparam logic [3:0] PROTO_SSH = 4'd4;
    localparam logic [3:0] PROTO_FTP = 4'd5;
    localparam logic [3:0] PROTO_SMTP = 4'd6;
    localparam logic [3:0] PROTO_DB = 4'd7;
    localparam logic [3:0] PROTO_RDP = 4'd8;

    localparam logic [1:0] METH_NONE = 2'd0;
    localparam logic [1:0] METH_DPI = 2'd1;
    localparam logic [1:0] METH_PORT = 2'd2;

    localparam logic [6:0] CONF_NONE = 7'd0;
    localparam logic [6:0] CONF_PORT = 7'd50;
    localparam logic [6:0] CONF_DPI = 7'd100;

    localparam logic [1:0] GRP_HTTP = 2'd0;
    localparam logic [1:0] GRP_SSH = 2'd1;
    localparam logic [1:0] GRP_FTP = 2'd2;
    localparam logic [1:0] GRP_SMTP = 2'd3;

    localparam logic [7:0] TLS_LEAD0 = 8'h16;
    localparam logic [7:0] TLS_LEAD1 = 8'h03;

    typedef struct packed {
        logic        l4_known;
        logic [1:0]  transport;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        has_byte;
        logic [7:0]  data_byte;
        logic        first;
        logic        last;
    } t_in_beat;

    typedef struct packed {
        logic [3:0] protocol;
        logic [6:0] confidence;
        logic [1:0] method;
    } t_out_beat;

    // The last character of a keyword sits in the low byte of text.
    typedef struct packed {
        logic [KW_MAX_LEN*8-1:0] text;
        logic [3:0]              len;
        logic [1:0]              grp;
    } t_kw;

    typedef struct packed {
        logic [15:0] port;
        logic [1:0]  transport;
        logic [3:0]  protocol;
    } t_port_entry;

    localparam t_kw KW_TABLE [NUM_KW] = '{
        '{80'("GET "), 4'd4, GRP_HTTP},
        '{80'("POST "), 4'd5, GRP_HTTP},
        '{80'("PUT "), 4'd4, GRP_HTTP},
        '{80'("DELETE "), 4'd7, GRP_HTTP},
        '{80'("HEAD "), 4'd5, GRP_HTTP},
        '{80'("HTTP/1."), 4'd7, GRP_HTTP},
        '{80'("HTTP/2"), 4'd6, GRP_HTTP},
        '{80'("SSH-"), 4'd4, GRP_SSH},
        '{80'("220 "), 4'd4, GRP_FTP},
        '{80'("USER "), 4'd5, GRP_FTP},
        '{80'("PASS "), 4'd5, GRP_FTP},
        '{80'("RETR "), 4'd5, GRP_FTP},
        '{80'("STOR "), 4'd5, GRP_FTP},
        '{80'("220 "), 4'd4, GRP_SMTP},
        '{80'("HELO "), 4'd5, GRP_SMTP},
        '{80'("EHLO "), 4'd5, GRP_SMTP},
        '{80'("MAIL FROM:"), 4'd10, GRP_SMTP},
        '{80'("RCPT TO:"), 4'd8, GRP_SMTP}
    };

    localparam t_port_entry PORT_TABLE [NUM_PORT_ENTRIES] = '{
        '{16'd80, TR_TCP, PROTO_HTTP},
        '{16'd8080, TR_TCP, PROTO_HTTP},
        '{16'd8000, TR_TCP, PROTO_HTTP},
        '{16'd8888, TR_TCP, PROTO_HTTP},
        '{16'd443, TR_TCP, PROTO_HTTPS},
        '{16'd8443, TR_TCP, PROTO_HTTPS},
        '{16'd53, TR_UDP, PROTO_DNS},
        '{16'd22, TR_TCP, PROTO_SSH},
        '{16'd21, TR_TCP, PROTO_FTP},
        '{16'd25, TR_TCP, PROTO_SMTP},
        '{16'd587, TR_TCP, PROTO_SMTP},
        '{16'd3306, TR_TCP, PROTO_DB},
        '{16'd3389, TR_TCP, PROTO_RDP}
    };

    function automatic logic is_kept(input logic [7:0] c);
        return (c >= 8'h20 && c <= 8'h7E) || c == 8'h0A || c == 8'h0D;
    endfunction

    // The earliest matching entry wins, so the walk runs from the end.
    function automatic logic [3:0] port_lookup(input logic [1:0] tr,
                                               input logic [15:0] sp,
                                               input logic [15:0] dp);
        logic [3:0] p;
        p = PROTO_UNKNOWN;
        for (int i = NUM_PORT_ENTRIES - 1; i >= 0; i--) begin
            if (PORT_TABLE[i].transport == tr &&
                (PORT_TABLE[i].port == dp || PORT_TABLE[i].port == sp)) begin
                p = PORT_TABLE[i].protocol;
            end
        end
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== design/app_pc_cell.sv =====
`default_nettype none
module app_pc_cell (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_clr_now,
    input  wire logic       i_shift,
    input  wire logic       i_clr_after,
    input  wire logic [7:0] i_prev,
    output logic [7:0]      o_view
);

    logic [7:0] r_char;
    logic [7:0] n_char;

    assign o_view = i_clr_now ? 8'h00 : r_char;

    always_comb begin
        if (i_clr_after) begin
            n_char = 8'h00;
        end else if (i_shift) begin
            n_char = i_prev;
        end else begin
            n_char = o_view;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char <= 8'h00;
        end else begin
            r_char <= n_char;
        end
    end

endmodule
`default_nettype wire

// ===== design/app_pc_match.sv =====
`default_nettype none
module app_pc_match import app_pc_pkg::*; (
    input  wire logic [KW_MAX_LEN*8-1:0] i_window,
    output logic [3:0]                   o_hits
);

    logic hit;

    always_comb begin
        o_hits = '0;
        hit = 1'b0;
        for (int k = 0; k < NUM_KW; k++) begin
            hit = 1'b1;
            for (int b = 0; b < KW_MAX_LEN; b++) begin
                if (4'(b) < KW_TABLE[k].len &&
                    i_window[8*b +: 8] != KW_TABLE[k].text[8*b +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                o_hits[KW_TABLE[k].grp] = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/app_protocol_classifier.sv =====
`default_nettype none
// Application protocol classifier.
// The input channel carries one beat per packet item: the first beat holds
// the transport context and ports, each beat may carry one payload byte, and
// the beat marked last closes the packet. One classification beat (protocol,
// confidence, method) leaves on the output channel for every last beat.
// One input beat is taken every clock cycle while the input is not stalled.
// The result is shown in the cycle after the last beat is taken and waits in
// the output register until taken. The printable bytes shift through a row of
// nine history cells, and the keyword compare against the cells and the new
// byte finishes within the cycle that takes the byte.
// While a result waits under stall, beats that are not last keep flowing; a
// last beat is stalled only until the waiting result leaves.
// The configuration channel is always ready and writes the enable bits.
// Reset clears the scan state, the held context and the output valid, and
// sets both enables.
module app_protocol_classifier import app_pc_pkg::*; #(
    parameter int SCAN_LIMIT = 200
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_beat             i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_beat                 o_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic                 i_cfg_data
);

    localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(SCAN_LIMIT);

    logic r_dpi_en;
    logic r_port_en;

    logic [COUNT_W-1:0] r_scan_count;
    logic [COUNT_W-1:0] n_scan_count;
    logic [7:0]         r_lead0;
    logic [7:0]         n_lead0;
    logic [7:0]         r_lead1;
    logic [7:0]         n_lead1;
    logic [3:0]         r_hits;
    logic [3:0]         n_hits;

    logic        r_l4_known;
    logic [1:0]  r_transport;
    logic [15:0] r_sport;
    logic [15:0] r_dport;
    logic        n_l4_known;
    logic [1:0]  n_transport;
    logic [15:0] n_sport;
    logic [15:0] n_dport;

    logic      r_out_valid;
    t_out_beat r_out;
    t_out_beat n_out;

    logic               acc;
    logic               clr_now;
    logic               clr_after;
    logic               take;
    logic               shift;
    logic [COUNT_W-1:0] base_count;
    logic [COUNT_W-1:0] pre_count;
    logic [7:0]         pre_lead0;
    logic [7:0]         pre_lead1;
    logic [3:0]         pre_hits;
    logic [3:0]         match_hits;
    logic [3:0]         dpi_proto;
    logic               dpi_done;

    logic [7:0]                   view [HIST_DEPTH];
    logic [KW_MAX_LEN*8-1:0]      window;

    assign acc = i_in_valid & ~o_in_stall;
    assign clr_now = acc & i_in.first;
    assign clr_after = acc & i_in.last;
    assign o_in_stall = r_out_valid & i_out_stall & i_in.last;
    assign o_out_valid = r_out_valid;
    assign o_out = r_out;
    assign o_cfg_ready = 1'b1;

    assign base_count = i_in.first ? '0 : r_scan_count;
    assign take = acc & i_in.has_byte & (base_count < LIMIT);
    assign shift = take & is_kept(i_in.data_byte);

    assign window[7:0] = i_in.data_byte;

    genvar g;
    generate
        for (g = 0; g < HIST_DEPTH; g++) begin : g_hist
            assign window[8*(g+1) +: 8] = view[g];
            app_pc_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_clr_now  (clr_now),
                .i_shift    (shift),
                .i_clr_after(clr_after),
                .i_prev     ((g == 0) ? i_in.data_byte : view[(g == 0) ? 0 : g-1]),
                .o_view     (view[g])
            );
        end
    endgenerate

    app_pc_match u_match (
        .i_window(window),
        .o_hits  (match_hits)
    );

    always_comb begin
        pre_count = take ? base_count + 1'b1 : base_count;
        pre_lead0 = i_in.first ? 8'h00 : r_lead0;
        pre_lead1 = i_in.first ? 8'h00 : r_lead1;
        pre_hits = i_in.first ? 4'h0 : r_hits;
        if (take && base_count == '0) begin
            pre_lead0 = i_in.data_byte;
        end
        if (take && base_count == COUNT_W'(1)) begin
            pre_lead1 = i_in.data_byte;
        end
        if (shift) begin
            pre_hits = pre_hits | match_hits;
        end
    end

    always_comb begin
        if (clr_now) begin
            n_l4_known = i_in.l4_known;
            n_transport = i_in.transport;
            n_sport = i_in.sport;
            n_dport = i_in.dport;
        end else begin
            n_l4_known = r_l4_known;
            n_transport = r_transport;
            n_sport = r_sport;
            n_dport = r_dport;
        end
        if (clr_after) begin
            n_scan_count = '0;
            n_lead0 = 8'h00;
            n_lead1 = 8'h00;
            n_hits = 4'h0;
        end else if (acc) begin
            n_scan_count = pre_count;
            n_lead0 = pre_lead0;
            n_lead1 = pre_lead1;
            n_hits = pre_hits;
        end else begin
            n_scan_count = r_scan_count;
            n_lead0 = r_lead0;
            n_lead1 = r_lead1;
            n_hits = r_hits;
        end
    end

    always_comb begin
        dpi_proto = PROTO_UNKNOWN;
        if (n_transport == TR_TCP) begin
            if (pre_hits[GRP_HTTP]) begin
                dpi_proto = PROTO_HTTP;
            end else if (pre_count >= COUNT_W'(2) && pre_lead0 == TLS_LEAD0 &&
                         pre_lead1 == TLS_LEAD1) begin
                dpi_proto = PROTO_HTTPS;
            end else if (pre_hits[GRP_SSH]) begin
                dpi_proto = PROTO_SSH;
            end else if (pre_hits[GRP_FTP]) begin
                dpi_proto = PROTO_FTP;
            end else if (pre_hits[GRP_SMTP]) begin
                dpi_proto = PROTO_SMTP;
            end
        end
        n_out.protocol = PROTO_UNKNOWN;
        n_out.confidence = CONF_NONE;
        n_out.method = METH_NONE;
        dpi_done = 1'b0;
        if (n_l4_known) begin
            if (r_dpi_en && pre_count != '0) begin
                n_out.method = METH_DPI;
                if (dpi_proto != PROTO_UNKNOWN) begin
                    n_out.protocol = dpi_proto;
                    n_out.confidence = CONF_DPI;
                    dpi_done = 1'b1;
                end
            end
            if (!dpi_done && r_port_en) begin
                n_out.method = METH_PORT;
                n_out.confidence = CONF_PORT;
                n_out.protocol = port_lookup(n_transport, n_sport, n_dport);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpi_en <= 1'b1;
            r_port_en <= 1'b1;
            r_scan_count <= '0;
            r_lead0 <= 8'h00;
            r_lead1 <= 8'h00;
            r_hits <= 4'h0;
            r_l4_known <= 1'b0;
            r_transport <= TR_OTHER;
            r_sport <= 16'h0000;
            r_dport <= 16'h0000;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DPI_ENABLE: begin
                        r_dpi_en <= i_cfg_data;
                    end
                    CFG_PORT_ENABLE: begin
                        r_port_en <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            r_scan_count <= n_scan_count;
            r_lead0 <= n_lead0;
            r_lead1 <= n_lead1;
            r_hits <= n_hits;
            r_l4_known <= n_l4_known;
            r_transport <= n_transport;
            r_sport <= n_sport;
            r_dport <= n_dport;
            if (clr_after) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (clr_after) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

// ===== design/app_pc_checker.sv =====
`default_nettype none
module app_pc_checker import app_pc_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_beat  i_in,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_beat o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("Result beat dropped while stalled.");

    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.last |=> o_out_valid)
        else $error("No result beat after a last input beat.");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall && i_in.last))
        else $error("Result beat without a last input beat.");

    a_conf_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.confidence == CONF_NONE ||
                         o_out.confidence == CONF_PORT ||
                         o_out.confidence == CONF_DPI))
        else $error("Confidence outside the known set.");

    a_dpi_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.confidence == CONF_DPI |->
            o_out.method == METH_DPI && o_out.protocol != PROTO_UNKNOWN)
        else $error("Payload match result without method or protocol.");

endmodule

bind app_protocol_classifier app_pc_checker u_app_pc_checker (.*);
`default_nettype wire

// ===== test/app_protocol_classifier_tb.sv =====
`timescale 1ns / 100ps
module app_protocol_classifier_tb;
    import app_pc_pkg::*;

    localparam int SCAN_MAX = 200;
    localparam int PHASE_BEATS = 10;
    localparam int IDLE_LIMIT = 2000;
    localparam int NUM_RULES = 13;

    // Bit 1 is the payload inspection enable, bit 0 the port table enable.
    localparam logic [1:0] MODES [4] = '{2'b01, 2'b10, 2'b00, 2'b11};

    localparam t_port_entry PORT_RULES [NUM_RULES] = '{
        '{16'd80, TR_TCP, PROTO_HTTP},
        '{16'd8080, TR_TCP, PROTO_HTTP},
        '{16'd8000, TR_TCP, PROTO_HTTP},
        '{16'd8888, TR_TCP, PROTO_HTTP},
        '{16'd443, TR_TCP, PROTO_HTTPS},
        '{16'd8443, TR_TCP, PROTO_HTTPS},
        '{16'd53, TR_UDP, PROTO_DNS},
        '{16'd22, TR_TCP, PROTO_SSH},
        '{16'd21, TR_TCP, PROTO_FTP},
        '{16'd25, TR_TCP, PROTO_SMTP},
        '{16'd587, TR_TCP, PROTO_SMTP},
        '{16'd3306, TR_TCP, PROTO_DB},
        '{16'd3389, TR_TCP, PROTO_RDP}
    };

    string keywords [NUM_KW] = '{
        "GET ", "POST ", "PUT ", "DELETE ", "HEAD ", "HTTP/1.", "HTTP/2",
        "SSH-",
        "220 ", "USER ", "PASS ", "RETR ", "STOR ",
        "220 ", "HELO ", "EHLO ", "MAIL FROM:", "RCPT TO:"
    };
    logic [1:0] keyword_grp [NUM_KW] = '{
        GRP_HTTP, GRP_HTTP, GRP_HTTP, GRP_HTTP, GRP_HTTP, GRP_HTTP, GRP_HTTP,
        GRP_SSH,
        GRP_FTP, GRP_FTP, GRP_FTP, GRP_FTP, GRP_FTP,
        GRP_SMTP, GRP_SMTP, GRP_SMTP, GRP_SMTP, GRP_SMTP
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_beat             i_in = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_beat            o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic                 i_cfg_data = 1'b0;

    logic        dpi_on;
    logic        port_on;
    int          scan_cnt;
    logic [7:0]  history [HIST_DEPTH];
    logic [7:0]  lead [2];
    logic [3:0]  hits;
    logic        held_known;
    logic [1:0]  held_tr;
    logic [15:0] held_sp;
    logic [15:0] held_dp;

    t_in_beat    beat_q [$];
    t_out_beat   verdict_q [$];
    logic [7:0]  frame [$];
    t_out_beat   want;
    int          n_queued = 0;
    int          n_taken = 0;
    int          errors = 0;
    int          idle_pct = 20;
    int          quiet_cycles = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    logic [31:0] cycle_cnt = '0;

    app_protocol_classifier dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic reset_scan();
        scan_cnt = 0;
        foreach (history[i]) history[i] = 8'h00;
        lead[0] = 8'h00;
        lead[1] = 8'h00;
        hits = 4'h0;
    endtask

    function automatic bit keyword_ends(input string kw, input logic [7:0] c);
        int n = kw.len();
        if (c != kw[n-1]) return 1'b0;
        for (int i = 1; i < n; i++) begin
            if (history[i-1] != kw[n-1-i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic scan_byte(input logic [7:0] c);
        if (scan_cnt >= SCAN_MAX) return;
        if (scan_cnt < 2) lead[scan_cnt] = c;
        scan_cnt++;
        if (!((c >= 8'h20 && c <= 8'h7E) || c == 8'h0A || c == 8'h0D)) return;
        foreach (keywords[i]) begin
            if (keyword_ends(keywords[i], c)) hits[keyword_grp[i]] = 1'b1;
        end
        for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
        history[0] = c;
    endtask

    function automatic t_out_beat packet_verdict();
        t_out_beat v;
        logic [3:0] p;
        v = '{PROTO_UNKNOWN, CONF_NONE, METH_NONE};
        p = PROTO_UNKNOWN;
        if (!held_known) return v;
        if (dpi_on && scan_cnt > 0) begin
            v.method = METH_DPI;
            if (held_tr == TR_TCP) begin
                if (hits[GRP_HTTP]) p = PROTO_HTTP;
                else if (scan_cnt >= 2 && lead[0] == TLS_LEAD0 && lead[1] == TLS_LEAD1)
                    p = PROTO_HTTPS;
                else if (hits[GRP_SSH]) p = PROTO_SSH;
                else if (hits[GRP_FTP]) p = PROTO_FTP;
                else if (hits[GRP_SMTP]) p = PROTO_SMTP;
            end
            if (p != PROTO_UNKNOWN) begin
                v.protocol = p;
                v.confidence = CONF_DPI;
                return v;
            end
        end
        if (port_on) begin
            v.method = METH_PORT;
            v.confidence = CONF_PORT;
            foreach (PORT_RULES[i]) begin
                if (PORT_RULES[i].transport == held_tr &&
                    (PORT_RULES[i].port == held_dp || PORT_RULES[i].port == held_sp)) begin
                    v.protocol = PORT_RULES[i].protocol;
                    return v;
                end
            end
        end
        return v;
    endfunction

    task automatic classify_beat(input t_in_beat b);
        if (b.first) begin
            reset_scan();
            held_known = b.l4_known;
            held_tr = b.transport;
            held_sp = b.sport;
            held_dp = b.dport;
        end
        if (b.has_byte) scan_byte(b.data_byte);
        if (b.last) begin
            verdict_q.insert(verdict_q.size(), packet_verdict());
            reset_scan();
        end
    endtask

    function automatic t_in_beat random_beat();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(t_in_beat)-1:0];
    endfunction

    function automatic logic [15:0] pick_port();
        int r = $urandom_range(9);
        if (r < 4) return PORT_RULES[$urandom_range(NUM_RULES - 1)].port;
        if (r == 4) return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
        return 16'($urandom_range(16'hFFFF));
    endfunction

    task automatic queue_beat(input t_in_beat b);
        beat_q.insert(beat_q.size(), b);
        n_queued++;
    endtask

    task automatic put_byte(input logic [7:0] c);
        frame.insert(frame.size(), c);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    // Turns the collected bytes into one packet. A continuation packet has no
    // first beat and runs on the context held from before.
    task automatic send_frame(input logic l4, input logic [1:0] tr, input logic [15:0] sp,
                              input logic [15:0] dp, input bit sparse, input bit cont);
        t_in_beat b;
        bit lead_beat;
        lead_beat = 1'b1;
        do begin
            b = random_beat();
            if (lead_beat && !cont) begin
                b.l4_known = l4;
                b.transport = tr;
                b.sport = sp;
                b.dport = dp;
            end
            b.first = lead_beat && !cont;
            if (frame.size() == 0) begin
                b.has_byte = 1'b0;
                b.last = 1'b1;
            end else if (sparse && $urandom_range(9) == 0) begin
                b.has_byte = 1'b0;
                b.last = 1'b0;
            end else begin
                b.has_byte = 1'b1;
                b.data_byte = frame.pop_front();
                b.last = (frame.size() == 0);
            end
            queue_beat(b);
            lead_beat = 1'b0;
        end while (!b.last);
    endtask

    task automatic random_traffic(input int count);
        int stop;
        int kind;
        int n;
        int r;
        logic [1:0] tr;
        string s;
        stop = n_queued + count;
        while (n_queued < stop) begin
            kind = $urandom_range(99);
            if (kind < 12) begin
                repeat ($urandom_range(1, 3)) queue_beat(random_beat());
            end else begin
                n = $urandom_range(0, 14);
                while (frame.size() < n) begin
                    case ($urandom_range(9))
                        0, 1, 2: put_text(keywords[$urandom_range(NUM_KW - 1)]);
                        3: begin
                            if (frame.size() == 0) begin
                                put_byte(TLS_LEAD0);
                                put_byte(TLS_LEAD1);
                            end else begin
                                put_byte(8'($urandom_range(8'h20, 8'h7E)));
                            end
                        end
                        4: put_byte(8'($urandom_range(8'hFF)));
                        5: put_byte(($urandom_range(1) != 0) ? 8'h0D : 8'h0A);
                        6: begin
                            s = keywords[$urandom_range(NUM_KW - 1)];
                            put_text(s.substr(0, $urandom_range(s.len() - 2)));
                        end
                        default: put_byte(8'($urandom_range(8'h20, 8'h7E)));
                    endcase
                end
                r = $urandom_range(99);
                tr = (r < 70) ? TR_TCP : (r < 85) ? TR_UDP : 2'($urandom_range(3));
                send_frame($urandom_range(9) != 0, tr, pick_port(), pick_port(), 1'b1, kind < 17);
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk); while (n_taken != n_queued || verdict_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (cycle_cnt[7:6] != 2'd0 && $urandom_range(99) < idle_pct) begin
                in_gap = $urandom_range(2);
                i_in_valid <= 1'b0;
            end else if (beat_q.size() != 0) begin
                i_in <= beat_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_gap = 0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else if (cycle_cnt[7:6] != 2'd1 && $urandom_range(99) < idle_pct) begin
            out_gap = $urandom_range(2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dpi_on = 1'b1;
            port_on = 1'b1;
            reset_scan();
            held_known = 1'b0;
            held_tr = TR_OTHER;
            held_sp = '0;
            held_dp = '0;
            quiet_cycles = 0;
            cycle_cnt <= '0;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
            quiet_cycles++;
            if (i_cfg_valid && o_cfg_ready) begin
                quiet_cycles = 0;
                if (i_cfg_index == CFG_DPI_ENABLE) dpi_on = i_cfg_data;
                else if (i_cfg_index == CFG_PORT_ENABLE) port_on = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                quiet_cycles = 0;
                n_taken++;
                classify_beat(i_in);
            end
            if (o_out_valid && !i_out_stall) begin
                quiet_cycles = 0;
                if (verdict_q.size() == 0) begin
                    $error("result beat with no packet waiting: protocol %0d", o_out.protocol);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_out.protocol !== want.protocol) begin
                        $error("protocol: expected %0d, got %0d", want.protocol, o_out.protocol);
                        errors++;
                    end
                    if (o_out.confidence !== want.confidence) begin
                        $error("confidence: expected %0d, got %0d",
                               want.confidence, o_out.confidence);
                        errors++;
                    end
                    if (o_out.method !== want.method) begin
                        $error("method: expected %0d, got %0d", want.method, o_out.method);
                        errors++;
                    end
                end
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("[app_protocol_classifier] ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        put_text("GET /");
        send_frame(1'b0, TR_TCP, 16'd40000, 16'd80, 1'b0, 1'b0);
        foreach (keywords[i]) begin
            put_text(keywords[i]);
            send_frame(1'b1, TR_TCP, 16'hFFFF, 16'd1234, 1'b0, 1'b0);
        end
        put_text("get ");
        send_frame(1'b1, TR_TCP, 16'h0000, 16'd80, 1'b0, 1'b0);
        put_byte(TLS_LEAD0);
        put_byte(TLS_LEAD1);
        put_byte(8'h01);
        send_frame(1'b1, TR_TCP, 16'd5000, 16'd6000, 1'b0, 1'b0);
        put_byte(TLS_LEAD0);
        send_frame(1'b1, TR_TCP, 16'd5000, 16'd443, 1'b0, 1'b0);
        put_byte(TLS_LEAD0);
        put_byte(TLS_LEAD1);
        put_text("GET ");
        send_frame(1'b1, TR_TCP, 16'd5000, 16'd6000, 1'b0, 1'b0);
        put_text("SS");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_text("H-");
        send_frame(1'b1, TR_TCP, 16'd7, 16'd9, 1'b0, 1'b0);
        send_frame(1'b1, TR_TCP, 16'd443, 16'd50000, 1'b0, 1'b0);
        put_text("GET ");
        send_frame(1'b1, TR_UDP, 16'd53, 16'd999, 1'b0, 1'b0);
        put_text("GET ");
        send_frame(1'b1, TR_OTHER, 16'd80, 16'd80, 1'b0, 1'b0);
        put_text("GET ");
        send_frame(1'b1, 2'd3, 16'd80, 16'd80, 1'b0, 1'b0);
        put_text("hello\r\n");
        send_frame(1'b1, TR_TCP, 16'd1, 16'd2, 1'b0, 1'b0);
        foreach (PORT_RULES[i]) begin
            if (i % 2 != 0) send_frame(1'b1, PORT_RULES[i].transport, PORT_RULES[i].port,
                                       16'd7, 1'b0, 1'b0);
            else send_frame(1'b1, PORT_RULES[i].transport, 16'd7, PORT_RULES[i].port,
                            1'b0, 1'b0);
        end
        // A keyword that ends on the last scanned byte, then one a byte too late.
        repeat (SCAN_MAX - 4) put_byte(8'h80);
        put_text("GET ");
        send_frame(1'b1, TR_TCP, 16'd9, 16'd9, 1'b0, 1'b0);
        repeat (SCAN_MAX - 3) put_byte(8'h80);
        put_text("GET ");
        send_frame(1'b1, TR_TCP, 16'd9, 16'd9, 1'b0, 1'b0);
        // Packets without a first beat run on the context held from before.
        put_text("x");
        send_frame(1'b1, TR_TCP, 16'd22, 16'd9, 1'b0, 1'b0);
        send_frame(1'b0, TR_UDP, 16'd0, 16'd0, 1'b0, 1'b1);
        put_text("RETR ");
        send_frame(1'b0, TR_UDP, 16'd0, 16'd0, 1'b0, 1'b1);

        random_traffic(PHASE_BEATS);
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            write_reg(CFG_DPI_ENABLE, MODES[p][1]);
            write_reg(CFG_PORT_ENABLE, MODES[p][0]);
            idle_pct = (p == 3) ? 0 : $urandom_range(10, 30);
            random_traffic(PHASE_BEATS);
        end
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("[app_protocol_classifier] OK");
        end else begin
            $display("[app_protocol_classifier] ERROR");
        end
        $finish;
    end

endmodule
